/* rtl/core/tcw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Text console character writer package
// Shared geometry constants, character codes, item types and control types.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;
  localparam int CELLS     = COLUMNS * ROWS;

  // Derived widths
  localparam int CW   = $clog2(COLUMNS);      // column register
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;  // row register
  localparam int AW   = $clog2(CELLS);        // screen address
  localparam int CNTW = $clog2(CELLS + 1);    // sweep counter, reaches CELLS
  localparam int IDX_W = 11;                  // cell and cursor index fields
  localparam int PW   = (AW > IDX_W) ? AW : IDX_W;

  // Intake queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h0F;
  localparam logic [15:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

  // Configuration register indexes
  localparam logic CFG_ATTRIBUTE = 1'b0;
  localparam logic CFG_LOCKED    = 1'b1;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_MARK  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef struct packed {
    req_t             req_type;
    logic [7:0]       char_code;
    logic [IDX_W-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] cursor_index;
    logic [15:0]      cell_data;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_PRINT,
    OP_BS,
    OP_TAB,
    OP_CR,
    OP_LF,
    OP_MARK,
    OP_CLEAR,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [7:0]       ch;
    logic [IDX_W-1:0] idx;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } push_t;

  typedef struct packed {
    logic init_busy;
  } status_t;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_COPY,
    ST_IDLE,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

/* rtl/core/text_console_character_writer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Text console character writer
// Text screen of attribute/character cells with cursor, wrap, scroll,
// clear, backspace limit and cell read-back.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  in        input      in_valid/in_stall   in_data (req_type, char_code,
//                                           cell_index)
//  out       output     out_valid/out_stall out_data (cursor_index, cell_data)
//  cfg       input      cfg_we              cfg_index, cfg_data
//
//  In the back end a plain request is dispatched with its cell access in
//  ST_IDLE, then loads the result register in ST_EMIT, since the cell-memory
//  read is registered.
//  Clear screen writes the blank to every cell; a scroll copies the screen one
//  row up through the memory read/write ports, then blanks the last row.
//  After reset a clearing pass fills the screen; intake is stalled during
//  it, configuration writes are taken.
//  A two-item queue keeps intake open while the back end works or the
//  result register is stalled.
// ----------------------------------------------------------------------------
module text_console_character_writer_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tcw_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tcw_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [7:0]         cfg_data
);
  import tcw_pkg::*;

  logic [7:0] attribute;
  logic       output_locked;
  status_t    status;
  push_t      push;
  logic       q_ready;
  logic       q_valid;
  logic       q_pop;
  op_t        q_op;

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      attribute     <= RESET_ATTR;
      output_locked <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ATTRIBUTE: attribute     <= cfg_data;
        CFG_LOCKED:    output_locked <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // Front: accept and classify items
  tcw_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .locked   (output_locked),
    .status   (status),
    .q_ready  (q_ready),
    .push     (push)
  );

  // Queue: hold classified operations until the back end is free
  tcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .ready      (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_op)
  );

  // Back: execute on the screen memory, drive results
  tcw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .attr      (attribute),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* rtl/core/tcw_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Text console front end
// Accepts request items and classifies them into screen operations.
// ----------------------------------------------------------------------------
module tcw_front (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tcw_pkg::in_item_t in_data,
  input  wire logic              locked,
  input  wire tcw_pkg::status_t  status,
  input  wire logic              q_ready,
  output tcw_pkg::push_t         push
);
  import tcw_pkg::*;

  op_t op;

  // Hold intake while the queue is full or the power-up clear runs
  assign in_stall = !q_ready || status.init_busy;

  always_comb begin
    op.kind = OP_NOP;
    op.ch   = in_data.char_code;
    op.idx  = in_data.cell_index;
    unique case (in_data.req_type)
      REQ_PUT: begin
        priority if (locked)                   op.kind = OP_NOP;
        else if (in_data.char_code == CH_BS)   op.kind = OP_BS;
        else if (in_data.char_code == CH_TAB)  op.kind = OP_TAB;
        else if (in_data.char_code == CH_CR)   op.kind = OP_CR;
        else if (in_data.char_code == CH_LF)   op.kind = OP_LF;
        else if (in_data.char_code >= CH_SPACE) op.kind = OP_PRINT;
        else                                   op.kind = OP_NOP;
      end
      REQ_MARK:  op.kind = OP_MARK;
      REQ_CLEAR: op.kind = OP_CLEAR;
      REQ_READ:  op.kind = OP_READ;
      default:   op.kind = OP_NOP;
    endcase
  end

  assign push.valid = in_valid && !in_stall;
  assign push.op    = op;

endmodule
`default_nettype wire

/* rtl/core/tcw_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Text console operation queue
// Short FIFO that decouples classification from execution.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tcw_pkg::push_t push,
  output logic                ready,
  input  wire logic           pop,
  output logic                head_valid,
  output tcw_pkg::op_t        head
);
  import tcw_pkg::*;

  op_t            entries [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           do_push;
  logic           do_pop;

  assign ready      = count < QCW'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign do_push    = push.valid && ready;
  assign do_pop     = pop && head_valid;

  function automatic logic [QPW-1:0] bump(input logic [QPW-1:0] p);
    bump = (p == QPW'(QUEUE_DEPTH - 1)) ? '0 : QPW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> count < QCW'(QUEUE_DEPTH))
    else $error("push offered to a full queue");

endmodule
`default_nettype wire

/* rtl/core/tcw_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Text console back end
// Executes screen operations on the cell memory, keeps the cursor and
// the backspace limit, and drives the result register.
// ----------------------------------------------------------------------------
module tcw_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       attr,
  input  wire logic             q_valid,
  input  wire tcw_pkg::op_t     q_op,
  output logic                  q_pop,
  output tcw_pkg::status_t      status,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output tcw_pkg::out_item_t    out_data
);
  import tcw_pkg::*;

  logic [15:0] screen [CELLS];

  state_t            state, state_next;
  logic [CW-1:0]     col, col_next;
  logic [RW-1:0]     row, row_next;
  logic [IDX_W-1:0]  limit, limit_next;
  logic [CNTW-1:0]   cnt, cnt_next;
  logic [15:0]       fill_val, fill_next;
  logic              emit_flag, emit_next;
  logic              rd_hit, rd_hit_next;
  logic              out_valid_next;
  out_item_t         out_data_next;

  logic              mem_we, mem_re;
  logic [AW-1:0]     waddr, raddr;
  logic [15:0]       wdata, rdata;

  logic [AW-1:0]     pos;
  logic [15:0]       blank;
  logic [CW:0]       col_t;
  logic [RW:0]       row_t;
  logic [CW:0]       tab_col [COLUMNS];
  logic              out_free;

  always_comb begin
    for (int i = 0; i < COLUMNS; i++) begin
      tab_col[i] = (CW+1)'(i - (i % TAB_WIDTH) + TAB_WIDTH);
    end
  end

  assign pos      = AW'(AW'(row) * AW'(COLUMNS) + AW'(col));
  assign blank    = {attr, CH_SPACE};
  assign out_free = !out_valid || !out_stall;
  assign status.init_busy = (state == ST_FILL) && !emit_flag;

  always_ff @(posedge clk) begin
    if (mem_we) screen[waddr] <= wdata;
    if (mem_re) rdata <= screen[raddr];
  end

  always_comb begin
    state_next     = state;
    col_next       = col;
    row_next       = row;
    limit_next     = limit;
    cnt_next       = cnt;
    fill_next      = fill_val;
    emit_next      = emit_flag;
    rd_hit_next    = rd_hit;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    waddr          = '0;
    raddr          = '0;
    wdata          = '0;
    col_t          = {1'b0, col};
    row_t          = {1'b0, row};
    unique case (state)
      ST_FILL: begin
        mem_we   = 1'b1;
        waddr    = cnt[AW-1:0];
        wdata    = fill_val;
        cnt_next = cnt + 1'b1;
        if (cnt == CNTW'(CELLS - 1)) begin
          state_next = emit_flag ? ST_EMIT : ST_IDLE;
        end
      end
      ST_COPY: begin
        // Read one row ahead, write the previous read back one row up
        if (cnt < CNTW'(CELLS)) begin
          mem_re = 1'b1;
          raddr  = cnt[AW-1:0];
        end
        if (cnt > CNTW'(COLUMNS)) begin
          mem_we = 1'b1;
          waddr  = AW'(cnt - CNTW'(COLUMNS + 1));
          wdata  = rdata;
        end
        cnt_next = cnt + 1'b1;
        if (cnt == CNTW'(CELLS)) begin
          state_next = ST_FILL;
          cnt_next   = CNTW'(CELLS - COLUMNS);
          fill_next  = blank;
          emit_next  = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_next             = 1'b1;
          out_data_next.cursor_index = IDX_W'(pos);
          out_data_next.cell_data    = rd_hit ? rdata : 16'h0000;
          rd_hit_next                = 1'b0;
          state_next                 = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = ST_EMIT;
          unique case (q_op.kind)
            OP_PRINT: begin
              mem_we = 1'b1;
              waddr  = pos;
              wdata  = {attr, q_op.ch};
              col_t  = col_t + 1'b1;
            end
            OP_BS: begin
              // Backspace at column zero blanks in place
              if (PW'(pos) > PW'(limit)) begin
                mem_we = 1'b1;
                wdata  = blank;
                if (col != '0) begin
                  col_t = col_t - 1'b1;
                  waddr = pos - 1'b1;
                end else begin
                  waddr = pos;
                end
              end
            end
            OP_TAB: col_t = tab_col[col];
            OP_CR:  col_t = '0;
            OP_LF: begin
              col_t = '0;
              row_t = row_t + 1'b1;
            end
            OP_MARK: limit_next = IDX_W'(pos);
            OP_CLEAR: begin
              col_t      = '0;
              row_t      = '0;
              cnt_next   = '0;
              fill_next  = blank;
              emit_next  = 1'b1;
              state_next = ST_FILL;
            end
            OP_READ: begin
              if (32'(q_op.idx) < CELLS) begin
                mem_re      = 1'b1;
                raddr       = AW'(q_op.idx);
                rd_hit_next = 1'b1;
              end
            end
            default: ;
          endcase
          if (col_t >= (CW+1)'(COLUMNS)) begin
            col_t = '0;
            row_t = row_t + 1'b1;
          end
          col_next = col_t[CW-1:0];
          if (row_t >= (RW+1)'(ROWS)) begin
            row_next   = RW'(ROWS - 1);
            cnt_next   = CNTW'(COLUMNS);
            state_next = ST_COPY;
          end else begin
            row_next = row_t[RW-1:0];
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      col       <= '0;
      row       <= '0;
      limit     <= '0;
      cnt       <= '0;
      fill_val  <= RESET_BLANK;
      emit_flag <= 1'b0;
      rd_hit    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      col       <= col_next;
      row       <= row_next;
      limit     <= limit_next;
      cnt       <= cnt_next;
      fill_val  <= fill_next;
      emit_flag <= emit_next;
      rd_hit    <= rd_hit_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_data_next;
  end

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(col) < COLUMNS) && (32'(row) < ROWS))
    else $error("cursor outside the screen");

  a_reset_clear: assert property (@(posedge clk)
    $fell(rst) |-> (state == ST_FILL) && !emit_flag)
    else $error("power-up clear not running after reset");

  a_copy_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY) |-> (cnt >= CNTW'(COLUMNS)) && (cnt <= CNTW'(CELLS)))
    else $error("scroll sweep counter out of range");

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Text console character writer testbench
// Drives character, mark, clear and read requests into the console and
// checks every result against a shadow screen, cursor and backspace limit
// kept in the bench. Both sides idle at random; attribute and lock change
// between traffic phases.
// ----------------------------------------------------------------------------
module tb_top;
  import tcw_pkg::*;

  localparam int SETTLE_CYCLES  = CELLS + 16;   // one full sweep plus margin
  localparam int TIMEOUT_CYCLES = 6_000_000;
  localparam int IDLE_PCT       = 25;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  in_item_t   in_data   = '0;
  logic       out_stall = 1'b0;
  logic       cfg_we    = 1'b0;
  logic       cfg_index = CFG_ATTRIBUTE;
  logic [7:0] cfg_data  = '0;
  logic       in_stall;
  logic       out_valid;
  out_item_t  out_data;

  // Shadow of the console: screen, cursor, backspace limit and registers
  logic [15:0]  shadow_screen [CELLS];
  int unsigned  cur_col;
  int unsigned  cur_row;
  int unsigned  bs_limit;
  logic [7:0]   cur_attr;
  logic         cur_locked;

  // Results still owed by the console, oldest first
  out_item_t    cursor_reports [$];

  int unsigned  useful_items;
  int           fail_count;
  bit           calm;           // set: neither side idles

  text_console_character_writer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow screen model
  // ---------------------------------------------------------------------------
  function automatic int unsigned cursor_at();
    return cur_row * COLUMNS + cur_col;
  endfunction

  function automatic logic [15:0] blank_cell();
    return {cur_attr, CH_SPACE};
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(8'h20, 8'hFF));
  endfunction

  task automatic put_char(input logic [7:0] ch);
    int unsigned pos;
    pos = cursor_at();
    case (ch)
      CH_BS: begin
        // At or below the limit the backspace is dropped entirely
        if (pos <= bs_limit) return;
        // At column zero the cursor holds but the cell under it is blanked
        if (cur_col != 0) cur_col--;
        shadow_screen[cursor_at()] = blank_cell();
      end
      CH_TAB: cur_col = cur_col - (cur_col % TAB_WIDTH) + TAB_WIDTH;
      CH_CR:  cur_col = 0;
      CH_LF: begin
        cur_col = 0;
        cur_row++;
      end
      default: begin
        // Remaining control codes leave everything as it is
        if (ch >= CH_SPACE) begin
          shadow_screen[pos] = {cur_attr, ch};
          cur_col++;
        end
      end
    endcase
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    // Past the last row: shift everything up one row, blank the new last row
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) shadow_screen[i] = shadow_screen[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) shadow_screen[i] = blank_cell();
      cur_row = ROWS - 1;
    end
  endtask

  // Advance the shadow by one accepted item and queue the result it owes
  task automatic apply_request(input in_item_t it);
    out_item_t res;
    res = '0;
    case (it.req_type)
      REQ_PUT:  if (!cur_locked) put_char(it.char_code);
      REQ_MARK: bs_limit = cursor_at() & 32'h7FF;
      REQ_CLEAR: begin
        // The backspace limit survives a clear
        for (int i = 0; i < CELLS; i++) shadow_screen[i] = blank_cell();
        cur_col = 0;
        cur_row = 0;
      end
      REQ_READ: begin
        // Reads past the screen return zero
        if (int'(it.cell_index) < CELLS) res.cell_data = shadow_screen[it.cell_index];
      end
      default: ;
    endcase
    res.cursor_index = IDX_W'(cursor_at());
    cursor_reports.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Item and register drivers
  // ---------------------------------------------------------------------------
  // Send one item; valid stays high on return so the next item can follow
  // back to back. Callers that let time pass lower it through wait_idle.
  task automatic send_request(input req_t req, input logic [7:0] ch,
                              input logic [IDX_W-1:0] idx);
    in_item_t it;
    it.req_type   = req;
    it.char_code  = ch;
    it.cell_index = idx;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    // Count only items that can change something
    if (req != REQ_PUT || (!cur_locked && (ch >= CH_SPACE || ch == CH_BS ||
        ch == CH_TAB || ch == CH_LF || ch == CH_CR)))
      useful_items++;
    apply_request(it);
  endtask

  task automatic put(input logic [7:0] ch);
    send_request(REQ_PUT, ch, IDX_W'($urandom));
  endtask

  task automatic read_cell(input logic [IDX_W-1:0] idx);
    send_request(REQ_READ, 8'($urandom), idx);
  endtask

  task automatic mark();
    send_request(REQ_MARK, 8'($urandom), IDX_W'($urandom));
  endtask

  task automatic clear_screen();
    send_request(REQ_CLEAR, 8'($urandom), IDX_W'($urandom));
  endtask

  // Drop valid and hold until every owed result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (cursor_reports.size() != 0) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges once the console is idle
  task automatic set_config(input logic [7:0] attr, input logic locked);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ATTRIBUTE;
    cfg_data  <= attr;
    @(posedge clk);
    cur_attr   = attr;
    cfg_index <= CFG_LOCKED;
    cfg_data  <= {7'b0, locked};
    @(posedge clk);
    cur_locked = locked;
    cfg_we    <= 1'b0;
  endtask

  // Mostly in-range cells, some near the cursor, some past the screen
  function automatic logic [IDX_W-1:0] pick_cell();
    int unsigned sel;
    int unsigned here;
    sel  = $urandom_range(99);
    here = cursor_at();
    if (sel < 10) return IDX_W'($urandom_range(CELLS, 2 ** IDX_W - 1));
    if (sel < 40) return IDX_W'((here >= 4) ? here - $urandom_range(4) : here);
    return IDX_W'($urandom_range(CELLS - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Fresh screen is all blanks in the reset color; reads past it return zero
  task automatic test_reset_contents();
    read_cell(IDX_W'(0));
    read_cell(IDX_W'(CELLS - 1));
    read_cell(IDX_W'(CELLS));
    read_cell(IDX_W'(2 ** IDX_W - 1));
    mark();
  endtask

  task automatic test_put_characters();
    put(CH_BS);             // cursor at the limit: nothing happens
    put(CH_SPACE);
    put(8'hFF);
    put(8'h00);             // stray control codes change nothing
    put(8'h1F);
    put(CH_TAB);
    put(8'h41);
    put(CH_CR);
    put(CH_LF);
    put(CH_BS);             // column zero above the limit: blank in place
    mark();
    put(8'h80);
    put(CH_BS);
    put(CH_BS);             // back at the limit
    read_cell(IDX_W'(8));
    read_cell(IDX_W'(COLUMNS));
  endtask

  // Locked puts are dropped; clear uses the new color and keeps the limit
  task automatic test_lock_and_clear();
    set_config(8'hA5, 1'b1);
    put(8'h5A);
    put(CH_LF);
    read_cell(IDX_W'(COLUMNS));
    set_config(8'hA5, 1'b0);
    put(8'h5A);
    clear_screen();
    read_cell(IDX_W'(COLUMNS));
    put(CH_BS);
  endtask

  // Walk lines down past the bottom, then wrap a row of tabs for one more scroll
  task automatic test_scroll();
    clear_screen();
    repeat (ROWS + 1) begin
      repeat ($urandom_range(0, 3)) put(printable());
      put(CH_LF);
    end
    repeat (COLUMNS / TAB_WIDTH) put(CH_TAB);
    read_cell(IDX_W'((ROWS - 1) * COLUMNS));
    read_cell(IDX_W'((ROWS - 2) * COLUMNS));
    read_cell(IDX_W'((ROWS - 2) * COLUMNS + 1));
    read_cell(IDX_W'(CELLS - 1));
  endtask

  // Random mix of text lines, reads, edits, noise and the odd clear
  task automatic run_traffic(input int unsigned quota);
    int unsigned goal;
    int unsigned pick;
    goal = useful_items + quota;
    while (useful_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        repeat ($urandom_range(1, 12)) put(printable());
        case ($urandom_range(3))
          0: put(CH_LF);
          1: begin
            put(CH_CR);
            put(CH_LF);
          end
          2: put(CH_TAB);
          default: ;
        endcase
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 4)) read_cell(pick_cell());
      end else if (pick < 82) begin
        // Mark, type a little, then backspace into and past the mark
        mark();
        repeat ($urandom_range(0, 4)) put(printable());
        repeat ($urandom_range(1, 6)) put(CH_BS);
        read_cell(IDX_W'(cursor_at()));
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 3))
          send_request(req_t'($urandom_range(3)), 8'($urandom), IDX_W'($urandom));
      end else begin
        clear_screen();
      end
    end
  endtask

  task automatic test_traffic_colored(input int unsigned quota);
    set_config(8'($urandom), 1'b0);
    run_traffic(quota);
  endtask

  // No idling on either side, black-on-black color
  task automatic test_traffic_back_to_back();
    calm = 1'b1;
    set_config(8'h00, 1'b0);
    run_traffic(80);
    wait_idle();
    calm = 1'b0;
  endtask

  task automatic test_traffic_locked();
    set_config(8'hFF, 1'b1);
    run_traffic(10);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  // Stall the result side at random except during the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (cursor_reports.size() == 0) begin
        $display("%0t: result with nothing owed, expected none actual %h", $time, out_data);
        fail_count++;
      end else begin
        want = cursor_reports.pop_front();
        if (out_data.cursor_index !== want.cursor_index) begin
          $display("%0t: cursor_index expected %0d actual %0d", $time,
                   want.cursor_index, out_data.cursor_index);
          fail_count++;
        end
        if (out_data.cell_data !== want.cell_data) begin
          $display("%0t: cell_data expected %h actual %h", $time,
                   want.cell_data, out_data.cell_data);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = RESET_BLANK;
    cur_col      = 0;
    cur_row      = 0;
    bs_limit     = 0;
    cur_attr     = RESET_ATTR;
    cur_locked   = 1'b0;
    useful_items = 0;
    fail_count   = 0;
    calm         = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_contents();
    test_put_characters();
    test_lock_and_clear();
    test_scroll();
    test_traffic_colored(100);
    test_traffic_back_to_back();
    test_traffic_locked();
    test_traffic_colored(100);

    // Let the last sweep finish and catch any stray result
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && cursor_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
rtl/core/tcw_pkg.sv
rtl/core/tcw_front.sv
rtl/core/tcw_queue.sv
rtl/core/tcw_back.sv
rtl/core/text_console_character_writer_top.sv
verif/tb_top.sv
